@@ rtl/core/bfdg_pkg.sv @@
// Shared constants, types and helpers for the box filter density grid block.
package bfdg_pkg;

   localparam int MAX_HALF    = 2;
   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 256;
   localparam int RING_ROWS   = 3 * MAX_HALF + 1;
   localparam int TAP_SIDE    = 2 * MAX_HALF + 1;
   localparam int TAP_COUNT   = TAP_SIDE * TAP_SIDE;
   localparam int QUEUE_DEPTH = 2;

   localparam int HALF_W  = $clog2(MAX_HALF + 1);
   localparam int COL_W   = $clog2(MAX_COLS + 1);
   localparam int XW      = $clog2(MAX_COLS);
   localparam int ROW_W   = $clog2(MAX_ROWS + 2 * MAX_HALF + 2);
   localparam int RING_W  = $clog2(RING_ROWS);
   localparam int TAP_W   = $clog2(TAP_COUNT);
   localparam int LS_DEPTH = RING_ROWS * MAX_COLS;
   localparam int LS_AW   = $clog2(LS_DEPTH);
   localparam int S_COL   = COL_W + 2;
   localparam int S_ROW   = ROW_W + 2;
   localparam int S_RING  = RING_W + 2;
   localparam int D_W     = HALF_W + 2;
   localparam int ACC_W   = 32 + $clog2(TAP_COUNT);
   localparam int SPLIT   = 20;
   localparam int SUM_W   = ACC_W + 17;
   localparam int RES_W   = SUM_W - 21;

   localparam logic signed [S_RING-1:0] RING_S = S_RING'(RING_ROWS);

   localparam logic [15:0] ONE_Q12 = 16'd4096;
   localparam logic [15:0] ONE_Q15 = 16'd32768;

   typedef enum logic [2:0] {
      REG_HALF_WIDTH    = 3'd0,
      REG_ROW_LENGTH    = 3'd1,
      REG_FRAME_ROWS    = 3'd2,
      REG_OUT_COL_LOW   = 3'd3,
      REG_OUT_COL_HIGH  = 3'd4,
      REG_OUT_ROW_HIGH  = 3'd5,
      REG_INV_THRESHOLD = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [HALF_W-1:0] half;
      logic [10:0]       len;
      logic [8:0]        rows;
      logic [9:0]        col_low;
      logic [10:0]       col_high;
      logic [7:0]        row_high;
      logic [15:0]       inv;
   } bfdg_cfg_type;

   typedef struct packed {
      logic        is_load;
      logic        tap_ok;
      logic [4:0]  tap;
      logic [15:0] value;
   } bfdg_item_type;

   function automatic logic [RING_W-1:0] mod_ring(input logic signed [S_RING-1:0] v);
      logic signed [S_RING-1:0] t;
      if (v < 0) begin
         t = v + RING_S;
      end else if (v >= RING_S) begin
         t = v - RING_S;
      end else begin
         t = v;
      end
      return t[RING_W-1:0];
   endfunction

endpackage

@@ rtl/core/bfdg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bfdg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ rtl/core/bfdg_front.sv @@
// Input front end: accepts beats, classifies them and queues them for the back end.
module bfdg_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_command,
   input  logic [4:0]              req_coef_index,
   input  logic [15:0]             req_value,
   input  logic                    hold,
   output logic                    item_valid,
   output bfdg_pkg::bfdg_item_type item,
   input  logic                    item_pop
);
   import bfdg_pkg::*;

   localparam int Q_AW = $clog2(QUEUE_DEPTH);
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   bfdg_item_type   q_ff [QUEUE_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff;
   logic [Q_AW-1:0] rd_ptr_ff;
   logic [QC_W-1:0] count_ff;
   logic            push;
   logic            pop;
   bfdg_item_type   incoming;

   assign req_stall  = (count_ff == QC_W'(QUEUE_DEPTH)) || hold;
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && item_valid;
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      incoming.is_load = !req_command;
      incoming.tap_ok  = ({1'b0, req_coef_index} < 6'(TAP_COUNT));
      incoming.tap     = req_coef_index;
      incoming.value   = req_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            q_ff[wr_ptr_ff] <= incoming;
            wr_ptr_ff <= (wr_ptr_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/core/bfdg_back.sv @@
// Back end: line buffers, coefficient table, tap sequencer, scaling and result register.
module bfdg_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bfdg_pkg::bfdg_cfg_type  cfg,
   input  logic                    item_valid,
   input  bfdg_pkg::bfdg_item_type item,
   output logic                    item_pop,
   output logic                    clearing,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [15:0]             rsp_density,
   output logic [9:0]              rsp_column,
   output logic [7:0]              rsp_row,
   output logic                    rsp_frame_end
);
   import bfdg_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_TAPS, ST_DRAIN, ST_SCALE_LO, ST_SCALE_HI, ST_SUM, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      K_ZERO, K_WALL, K_LINE
   } kind_type;

   state_type state_ff, state_in;

   logic [15:0]       coef_ff [TAP_COUNT];
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [RING_W-1:0] ring_ff;
   logic [LS_AW-1:0]  clr_ff;

   logic [COL_W-1:0]         oc_ff;
   logic signed [S_ROW-1:0]  orow_ff;
   logic [RING_W-1:0]        oring_ff;
   logic                     fend_ff;
   logic signed [D_W-1:0]    dx_ff, dy_ff;
   logic [TAP_W-1:0]         tap_ff;

   logic                     s1_valid_ff;
   kind_type                 s1_kind_ff;
   logic [15:0]              s1_coef_ff;
   logic                     p_valid_ff;
   logic [31:0]              prod_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic [SPLIT+15:0]        plo_ff;
   logic [ACC_W-SPLIT+15:0]  phi_ff;
   logic [SUM_W-1:0]         sum_ff;

   // Sample bookkeeping.
   logic                     wrap;
   logic [COL_W-1:0]         col_w, col_n;
   logic [ROW_W-1:0]         row_w;
   logic [RING_W-1:0]        ring_w, ring_n;
   logic signed [S_COL-1:0]  col_w_s, half_c_s, len_s, d_s, oc_s;
   logic signed [S_ROW-1:0]  row_w_s, half_r_s, k_r_s, rows_s, orow_s, rhigh_s;
   logic signed [S_RING-1:0] ring_w_s, half_g_s, k_g_s;
   logic [1:0]               k;
   logic [COL_W-1:0]         oc;
   logic [RING_W-1:0]        oring;
   logic                     produce, last, in_win, sample_go;

   // Tap addressing.
   logic signed [S_COL-1:0]  x_s;
   logic signed [S_ROW-1:0]  y_s;
   logic signed [S_RING-1:0] tr_s;
   logic [RING_W-1:0]        ring_t;
   kind_type                 kind_t;
   logic signed [D_W-1:0]    f_d;
   logic                     dx_end, dy_end;

   logic                     ls_we;
   logic [LS_AW-1:0]         ls_waddr, ls_raddr;
   logic [15:0]              ls_wdata, ls_rdata, wall_rdata;
   logic                     wall_we;
   logic [15:0]              tap_sample;
   logic [RES_W-1:0]         res;
   logic                     out_free;

   assign wrap    = (col_ff >= cfg.len);
   assign col_w   = wrap ? '0 : col_ff;
   assign row_w   = wrap ? row_ff + 1'b1 : row_ff;
   assign ring_w  = wrap ? ((ring_ff == RING_W'(RING_ROWS - 1)) ? '0 : ring_ff + 1'b1)
                         : ring_ff;

   assign col_w_s  = {2'b00, col_w};
   assign half_c_s = {{(S_COL - HALF_W){1'b0}}, cfg.half};
   assign len_s    = {2'b00, cfg.len};
   assign d_s      = col_w_s - half_c_s;

   always_comb begin
      if (d_s >= 0) begin
         k    = 2'd0;
         oc_s = d_s;
      end else if (d_s + len_s >= 0) begin
         k    = 2'd1;
         oc_s = d_s + len_s;
      end else begin
         k    = 2'd2;
         oc_s = d_s + len_s + len_s;
      end
   end

   assign oc       = oc_s[COL_W-1:0];
   assign row_w_s  = {2'b00, row_w};
   assign half_r_s = {{(S_ROW - HALF_W){1'b0}}, cfg.half};
   assign k_r_s    = {{(S_ROW - 2){1'b0}}, k};
   assign rows_s   = {{(S_ROW - 9){1'b0}}, cfg.rows};
   assign rhigh_s  = {{(S_ROW - 8){1'b0}}, cfg.row_high};
   assign orow_s   = row_w_s - half_r_s - k_r_s;
   assign ring_w_s = {2'b00, ring_w};
   assign half_g_s = {{(S_RING - HALF_W){1'b0}}, cfg.half};
   assign k_g_s    = {{(S_RING - 2){1'b0}}, k};
   assign oring    = mod_ring(ring_w_s - half_g_s - k_g_s);

   assign produce = (orow_s >= 0) && (orow_s < rows_s);
   assign last    = (orow_s >= rows_s) ||
                    ((orow_s == rows_s - 1) && (oc == cfg.len - 1'b1));
   assign in_win  = (oc >= {1'b0, cfg.col_low}) && (oc < cfg.col_high) &&
                    (orow_s <= rhigh_s);

   assign col_n  = col_w + 1'b1;
   assign ring_n = (ring_w == RING_W'(RING_ROWS - 1)) ? '0 : ring_w + 1'b1;

   assign sample_go = (state_ff == ST_IDLE) && item_valid && !item.is_load;
   assign item_pop  = (state_ff == ST_IDLE) && item_valid;
   assign clearing  = (state_ff == ST_CLEAR);

   // Tap address generation for the current window position.
   assign f_d    = {{(D_W - HALF_W){1'b0}}, cfg.half};
   assign x_s    = $signed({2'b00, oc_ff}) + {{(S_COL - D_W){dx_ff[D_W-1]}}, dx_ff};
   assign y_s    = orow_ff + {{(S_ROW - D_W){dy_ff[D_W-1]}}, dy_ff};
   assign tr_s   = $signed({2'b00, oring_ff}) + {{(S_RING - D_W){dy_ff[D_W-1]}}, dy_ff};
   assign ring_t = mod_ring(tr_s);
   assign dx_end = (dx_ff == f_d);
   assign dy_end = (dy_ff == f_d);

   always_comb begin
      if ((x_s < 0) || (x_s >= len_s)) begin
         kind_t = K_ZERO;
      end else if (y_s < 0) begin
         kind_t = K_WALL;
      end else if (y_s >= rows_s) begin
         kind_t = K_ZERO;
      end else begin
         kind_t = K_LINE;
      end
   end

   assign ls_raddr = LS_AW'(ring_t) * LS_AW'(MAX_COLS) + LS_AW'(x_s[XW-1:0]);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ls_we    = 1'b1;
         ls_waddr = clr_ff;
         ls_wdata = '0;
      end else begin
         ls_we    = sample_go && ({1'b0, row_w} < {{(ROW_W + 1 - 9){1'b0}}, cfg.rows});
         ls_waddr = LS_AW'(ring_w) * LS_AW'(MAX_COLS) + LS_AW'(col_w[XW-1:0]);
         ls_wdata = item.value;
      end
   end

   assign wall_we = ls_we && (state_ff != ST_CLEAR) && (row_w == '0);

   bfdg_ram #(.WIDTH(16), .DEPTH(LS_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (ls_we),
      .wr_addr (ls_waddr),
      .wr_data (ls_wdata),
      .rd_addr (ls_raddr),
      .rd_data (ls_rdata)
   );

   bfdg_ram #(.WIDTH(16), .DEPTH(MAX_COLS)) u_wall_ram (
      .clock   (clock),
      .wr_en   (wall_we),
      .wr_addr (col_w[XW-1:0]),
      .wr_data (item.value),
      .rd_addr (x_s[XW-1:0]),
      .rd_data (wall_rdata)
   );

   always_comb begin
      case (s1_kind_ff)
         K_WALL:  tap_sample = (wall_rdata != '0) ? ONE_Q12 : '0;
         K_LINE:  tap_sample = ls_rdata;
         default: tap_sample = '0;
      endcase
   end

   assign res      = sum_ff[SUM_W-1:21];
   assign out_free = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (clr_ff == LS_AW'(LS_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (sample_go && produce) begin
               state_in = in_win ? ST_TAPS : ST_EMIT;
            end
         end
         ST_TAPS:     if (dx_end && dy_end) state_in = ST_DRAIN;
         ST_DRAIN:    if (!s1_valid_ff && !p_valid_ff) state_in = ST_SCALE_LO;
         ST_SCALE_LO: state_in = ST_SCALE_HI;
         ST_SCALE_HI: state_in = ST_SUM;
         ST_SUM:      state_in = ST_EMIT;
         ST_EMIT:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         ring_ff     <= '0;
         s1_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
         rsp_valid   <= 1'b0;
         for (int i = 0; i < TAP_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_IDLE && item_valid && item.is_load && item.tap_ok) begin
            coef_ff[item.tap[TAP_W-1:0]] <= item.value;
         end
         if (sample_go) begin
            if (last) begin
               col_ff  <= '0;
               row_ff  <= '0;
               ring_ff <= '0;
            end else if (col_n >= cfg.len) begin
               col_ff  <= '0;
               row_ff  <= row_w + 1'b1;
               ring_ff <= ring_n;
            end else begin
               col_ff  <= col_n;
               row_ff  <= row_w;
               ring_ff <= ring_w;
            end
            oc_ff    <= oc;
            orow_ff  <= orow_s;
            oring_ff <= oring;
            fend_ff  <= (orow_s == rows_s - 1) && (oc == cfg.len - 1'b1);
            dx_ff    <= -f_d;
            dy_ff    <= -f_d;
            tap_ff   <= '0;
            acc_ff   <= '0;
            sum_ff   <= '0;
         end
         s1_valid_ff <= (state_ff == ST_TAPS);
         s1_kind_ff  <= kind_t;
         s1_coef_ff  <= coef_ff[tap_ff];
         if (state_ff == ST_TAPS) begin
            tap_ff <= tap_ff + 1'b1;
            if (dx_end) begin
               dx_ff <= -f_d;
               dy_ff <= dy_ff + 1'b1;
            end else begin
               dx_ff <= dx_ff + 1'b1;
            end
         end
         p_valid_ff <= s1_valid_ff;
         prod_ff    <= tap_sample * s1_coef_ff;
         if (p_valid_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
         if (state_ff == ST_SCALE_LO) begin
            plo_ff <= acc_ff[SPLIT-1:0] * cfg.inv;
         end
         if (state_ff == ST_SCALE_HI) begin
            phi_ff <= acc_ff[ACC_W-1:SPLIT] * cfg.inv;
         end
         if (state_ff == ST_SUM) begin
            sum_ff <= SUM_W'({phi_ff, {SPLIT{1'b0}}}) + SUM_W'(plo_ff) + (SUM_W'(1) << 20);
         end
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid     <= 1'b1;
            rsp_density   <= (res > RES_W'(ONE_Q15)) ? ONE_Q15 : res[15:0];
            rsp_column    <= oc_ff[9:0];
            rsp_row       <= orow_ff[7:0];
            rsp_frame_end <= fend_ff;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

endmodule

@@ rtl/core/box_filter_density_grid_top.sv @@
// Top level of the box filter density grid block: register port, front end and back end.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_stall    req_command, req_coef_index, req_value
//  rsp      out        rsp_valid/rsp_stall    rsp_density, rsp_column, rsp_row, rsp_frame_end
//  csr      in/out     psel/penable/pready    paddr, pwrite, pwdata, prdata
//
// A coefficient load or a sample that yields no result is popped while the back end stays idle.
// A filtered result goes through the tap sequencer, which reads the line buffer RAM through
// its single read port one tap per cycle, then scaling; out-of-window results skip to emit.
// After reset all 7168 line buffer entries are cleared while req_stall stays high.
// A two-beat queue decouples intake; a stalled result register holds the back end in place.
module box_filter_density_grid_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [4:0]  req_coef_index,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_density,
   output logic [9:0]  rsp_column,
   output logic [7:0]  rsp_row,
   output logic        rsp_frame_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bfdg_pkg::*;

   logic [1:0]  half_ff;
   logic [10:0] len_ff;
   logic [8:0]  rows_ff;
   logic [9:0]  col_low_ff;
   logic [10:0] col_high_ff;
   logic [7:0]  row_high_ff;
   logic [15:0] inv_ff;

   bfdg_cfg_type  cfg;
   bfdg_item_type item;
   logic          item_valid, item_pop, clearing;
   reg_index_type idx;
   logic          wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;
   assign idx    = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff     <= 2'd1;
         len_ff      <= 11'd256;
         rows_ff     <= 9'd64;
         col_low_ff  <= 10'd0;
         col_high_ff <= 11'd256;
         row_high_ff <= 8'd63;
         inv_ff      <= 16'd256;
      end else if (wr) begin
         case (idx)
            REG_HALF_WIDTH:    half_ff     <= pwdata[1:0];
            REG_ROW_LENGTH:    len_ff      <= pwdata[10:0];
            REG_FRAME_ROWS:    rows_ff     <= pwdata[8:0];
            REG_OUT_COL_LOW:   col_low_ff  <= pwdata[9:0];
            REG_OUT_COL_HIGH:  col_high_ff <= pwdata[10:0];
            REG_OUT_ROW_HIGH:  row_high_ff <= pwdata[7:0];
            REG_INV_THRESHOLD: inv_ff      <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_HALF_WIDTH:    prdata = {30'd0, half_ff};
         REG_ROW_LENGTH:    prdata = {21'd0, len_ff};
         REG_FRAME_ROWS:    prdata = {23'd0, rows_ff};
         REG_OUT_COL_LOW:   prdata = {22'd0, col_low_ff};
         REG_OUT_COL_HIGH:  prdata = {21'd0, col_high_ff};
         REG_OUT_ROW_HIGH:  prdata = {24'd0, row_high_ff};
         REG_INV_THRESHOLD: prdata = {16'd0, inv_ff};
         default:           prdata = '0;
      endcase
   end

   always_comb begin
      cfg.half     = ({1'b0, half_ff} > 3'(MAX_HALF)) ? HALF_W'(MAX_HALF) : HALF_W'(half_ff);
      cfg.len      = (len_ff == '0) ? 11'd1 :
                     ((len_ff > 11'(MAX_COLS)) ? 11'(MAX_COLS) : len_ff);
      cfg.rows     = (rows_ff == '0) ? 9'd1 :
                     (({1'b0, rows_ff} > 10'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows_ff);
      cfg.col_low  = col_low_ff;
      cfg.col_high = col_high_ff;
      cfg.row_high = row_high_ff;
      cfg.inv      = inv_ff;
   end

   bfdg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_coef_index (req_coef_index),
      .req_value      (req_value),
      .hold           (clearing),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   bfdg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .clearing      (clearing),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_density   (rsp_density),
      .rsp_column    (rsp_column),
      .rsp_row       (rsp_row),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

@@ test/box_filter_density_grid_top_test.sv @@
// Self-checking testbench for the box filter density grid block with a scoreboard class.
module box_filter_density_grid_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bfdg_pkg::*;

   typedef struct {
      logic [15:0] density;
      logic [9:0]  column;
      logic [7:0]  row;
      logic        frame_end;
   } grid_result_type;

   class density_scoreboard;
      logic [15:0] line_mem[RING_ROWS*MAX_COLS];
      logic [15:0] wall_mem[MAX_COLS];
      logic [15:0] taps[TAP_COUNT];
      int unsigned col_pos, row_pos;
      int unsigned half, len, rows, col_low, col_high, row_high, inv;
      grid_result_type expected_q[$];
      int errors;

      function new();
         foreach (line_mem[i]) line_mem[i] = 0;
         foreach (wall_mem[i]) wall_mem[i] = 0;
         foreach (taps[i]) taps[i] = 0;
         col_pos = 0; row_pos = 0;
         half = 1; len = 256; rows = 64;
         col_low = 0; col_high = 256; row_high = 63; inv = 256;
         errors = 0;
      endfunction

      function void set_reg(reg_index_type idx, int unsigned v);
         case (idx)
            REG_HALF_WIDTH:    half = v & 'h3;
            REG_ROW_LENGTH:    len = v & 'h7ff;
            REG_FRAME_ROWS:    rows = v & 'h1ff;
            REG_OUT_COL_LOW:   col_low = v & 'h3ff;
            REG_OUT_COL_HIGH:  col_high = v & 'h7ff;
            REG_OUT_ROW_HIGH:  row_high = v & 'hff;
            REG_INV_THRESHOLD: inv = v & 'hffff;
            default: ;
         endcase
      endfunction

      function int unsigned eff_half();
         return half > MAX_HALF ? MAX_HALF : half;
      endfunction
      function int unsigned eff_len();
         if (len == 0) return 1;
         return len > MAX_COLS ? MAX_COLS : len;
      endfunction
      function int unsigned eff_rows();
         if (rows == 0) return 1;
         return rows > MAX_ROWS ? MAX_ROWS : rows;
      endfunction

      function longint unsigned sample_at(int x, int y, int l, int r);
         if (x < 0 || x >= l) return 0;
         if (y < 0) return wall_mem[x] != 0 ? 4096 : 0;
         if (y >= r) return 0;
         return line_mem[(y % RING_ROWS) * MAX_COLS + x];
      endfunction

      function logic [15:0] filtered(int cx, int ry, int f, int l, int r);
         longint unsigned acc, res;
         int side;
         acc = 0;
         side = 2 * f + 1;
         for (int dy = -f; dy <= f; dy++)
            for (int dx = -f; dx <= f; dx++)
               acc += longint'(taps[(dy + f) * side + (dx + f)]) *
                      sample_at(cx + dx, ry + dy, l, r);
         res = (acc * inv + (64'd1 << 20)) >> 21;
         return res > 32768 ? 16'd32768 : res[15:0];
      endfunction

      function void note_item(logic cmd, logic [4:0] idx, logic [15:0] val);
         int unsigned l, f, r;
         longint unsigned pos, lag, total, q;
         grid_result_type e;
         if (!cmd) begin
            if (idx < TAP_COUNT) taps[idx] = val;
            return;
         end
         l = eff_len(); f = eff_half(); r = eff_rows();
         if (col_pos >= l) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos < r) begin
            line_mem[(row_pos % RING_ROWS) * MAX_COLS + col_pos] = val;
            if (row_pos == 0) wall_mem[col_pos] = val;
         end
         pos = longint'(row_pos) * l + col_pos;
         lag = longint'(f) * l + f;
         total = longint'(r + f) * l + f;
         if (pos >= lag && pos < total) begin
            q = pos - lag;
            if (q < longint'(r) * l) begin
               e.column = 10'(q % l);
               e.row = 8'(q / l);
               e.density = '0;
               if ((q % l) >= col_low && (q % l) < col_high && (q / l) <= row_high)
                  e.density = filtered(int'(q % l), int'(q / l), f, l, r);
               e.frame_end = (q == longint'(r) * l - 1);
               expected_q.push_back(e);
            end
         end
         col_pos++;
         if (col_pos >= l) begin
            col_pos = 0;
            row_pos++;
         end
         if (pos + 1 >= total) begin
            col_pos = 0;
            row_pos = 0;
         end
      endfunction

      function void check_result(grid_result_type a);
         grid_result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result beat column %0d row %0d", a.column, a.row);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (a.density !== e.density) begin
            $error("density expected %0d actual %0d", e.density, a.density); errors++;
         end
         if (a.column !== e.column) begin
            $error("column expected %0d actual %0d", e.column, a.column); errors++;
         end
         if (a.row !== e.row) begin
            $error("row expected %0d actual %0d", e.row, a.row); errors++;
         end
         if (a.frame_end !== e.frame_end) begin
            $error("frame_end expected %0d actual %0d", e.frame_end, a.frame_end); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_command = 0;
   logic [4:0]  req_coef_index = 0;
   logic [15:0] req_value = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [15:0] rsp_density;
   logic [9:0]  rsp_column;
   logic [7:0]  rsp_row;
   logic        rsp_frame_end;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [4:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   density_scoreboard sb = new();
   bit no_gaps = 0;
   bit hold_request = 0;
   int idle_cycles = 0;
   int sent = 0;
   localparam int WATCHDOG_LIMIT = 50000;

   box_filter_density_grid_top dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("box_filter_density_grid_top_test: done, errors");
         $finish;
      end
   end

   initial begin
      int n;
      grid_result_type a;
      @(negedge clock);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 4);
         if (hold_request) begin
            n = 300;
            hold_request = 0;
         end
         rsp_stall = (n > 0);
         repeat (n) @(negedge clock);
         rsp_stall = 0;
         do @(posedge clock); while (!rsp_valid);
         a.density = rsp_density;
         a.column = rsp_column;
         a.row = rsp_row;
         a.frame_end = rsp_frame_end;
         sb.check_result(a);
         @(negedge clock);
      end
   end

   task automatic send_beat(logic cmd, logic [4:0] idx, logic [15:0] val);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_command = cmd;
      req_coef_index = idx;
      req_value = val;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sb.note_item(cmd, idx, val);
      sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, int unsigned v);
      req_valid = 0;
      psel = 1; pwrite = 1; penable = 0;
      paddr = 5'(int'(idx) * 4);
      pwdata = v;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, v);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   task automatic wait_drained();
      req_valid = 0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 8191));
      endcase
   endfunction

   task automatic run_frames(int f, int l, int r, int cl, int ch, int rh, int inv, int frames);
      int steps;
      wait_drained();
      write_reg(REG_HALF_WIDTH, f);
      write_reg(REG_ROW_LENGTH, l);
      write_reg(REG_FRAME_ROWS, r);
      write_reg(REG_OUT_COL_LOW, cl);
      write_reg(REG_OUT_COL_HIGH, ch);
      write_reg(REG_OUT_ROW_HIGH, rh);
      write_reg(REG_INV_THRESHOLD, inv);
      steps = (sb.eff_rows() + sb.eff_half()) * sb.eff_len() + sb.eff_half();
      repeat (frames) begin
         for (int s = 0; s < steps; s++) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(1'b0, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
            send_beat(1'b1, 5'd0, rand_sample());
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 0;
      send_beat(1'b0, 5'd0, 16'hffff);
      send_beat(1'b0, 5'd24, 16'hffff);
      send_beat(1'b0, 5'd31, 16'h1234);
      send_beat(1'b0, 5'd25, 16'h0);
      for (int i = 0; i < 9; i++) send_beat(1'b0, i[4:0], 16'h2000 + 16'(i));
      run_frames(1, 4, 3, 0, 4, 255, 256, 1);
      run_frames(0, 1, 2, 0, 1024, 0, 65535, 2);
      hold_request = 1;
      run_frames(2, 5, 4, 1, 3, 2, 4096, 1);
      run_frames(3, 6, 5, 1023, 0, 255, 0, 1);
      run_frames(0, 1024, 0, 0, 1024, 255, 300, 1);
      run_frames(1, 1, 256, 0, 2, 200, 1024, 1);
      while (sent < 1600) begin
         int f, l, r, inv;
         f = $urandom_range(0, 2);
         l = $urandom_range(1, 12);
         r = $urandom_range(2, 8);
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) hold_request = 1;
         inv = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 65535);
         run_frames(f, l, r, $urandom_range(0, l), $urandom_range(0, l + 1),
                    $urandom_range(0, r), inv, $urandom_range(1, 2));
      end
      no_gaps = 0;
      wait_drained();
      if (sb.errors == 0) begin
         $display("box_filter_density_grid_top_test: done, clean");
      end else begin
         $display("box_filter_density_grid_top_test: done, errors");
      end
      $finish;
   end
endmodule
